FILE: hw/rtl/obpm_pkg.sv
// ----------------------------------------------------------------------------
// obpm_pkg
// Shared types and codes for the online best partner matcher.
// ----------------------------------------------------------------------------
package obpm_pkg;

  localparam int unsigned ID_W    = 6;
  localparam int unsigned COORD_W = 32;
  localparam int unsigned WGT_W   = 32;
  localparam int unsigned REACH_W = 31;
  localparam int unsigned UTIL_W  = 48;
  localparam int unsigned IDXO_W  = 6;

  localparam logic [1:0] REQ_LOAD   = 2'd0;
  localparam logic [1:0] REQ_WORKER = 2'd1;
  localparam logic [1:0] REQ_TASK   = 2'd2;

  localparam logic [1:0] ST_NONE    = 2'd0;
  localparam logic [1:0] ST_MATCHED = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_LOADED  = 2'd3;

  typedef struct packed {
    logic [REACH_W-1:0] reach;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
    logic [ID_W-1:0]    id;
  } worker_ent_t;

  typedef struct packed {
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
    logic [ID_W-1:0]    id;
  } task_ent_t;

endpackage

FILE: hw/rtl/online_best_partner_matcher.sv
// ----------------------------------------------------------------------------
// online_best_partner_matcher
// Online worker/task matcher: stores arrivals, scans the opposite store for
// the best free partner in reach, and keeps a saturating utility sum.
// ----------------------------------------------------------------------------
// channel  dir  tuser          tdata
// s_axis   in   req_type       node_id, other_id, weight_value, pos_x, pos_y, reach
// m_axis   out  status         partner_index, new_index, match_weight, total_utility
//
// Weight loads, unknown requests and dropped arrivals skip the scan.
// An arrival scans every filled entry of the opposite store, one store read
// per cycle through a four-stage read/distance/weight/select pipeline.
// One item at a time; the next is taken once the result sits in the output
// register, even while that register waits on m_axis_tready_i.
// Reset clears counts, utility and control; memories are not cleared.
// ----------------------------------------------------------------------------
module online_best_partner_matcher
  import obpm_pkg::*;
#(
  parameter int unsigned MAX_WORKERS = 64,
  parameter int unsigned MAX_TASKS   = 64,
  parameter int unsigned MAX_IDS     = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // node_id[5:0], other_id[11:6], weight_value[43:12], pos_x[75:44],
  // pos_y[107:76], reach[138:108], zero pad
  input  logic [143:0] s_axis_tdata_i,
  // req_type[1:0]
  input  logic [1:0]   s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // partner_index[5:0], new_index[11:6], match_weight[43:12],
  // total_utility[91:44], zero pad
  output logic [95:0]  m_axis_tdata_o,
  // status[1:0]
  output logic [1:0]   m_axis_tuser_o
);

  localparam int unsigned MAXN   = (MAX_WORKERS > MAX_TASKS) ? MAX_WORKERS : MAX_TASKS;
  localparam int unsigned CNT_W  = $clog2(MAXN + 1);
  localparam int unsigned IDX_W  = $clog2(MAXN);
  localparam int unsigned WA_W   = $clog2(MAX_WORKERS);
  localparam int unsigned TA_W   = $clog2(MAX_TASKS);
  localparam int unsigned WDEPTH = MAX_IDS * MAX_IDS;
  localparam int unsigned WMA_W  = $clog2(WDEPTH);
  localparam int unsigned SQ_W   = 2 * (COORD_W + 1);
  localparam int unsigned R2_W   = 2 * REACH_W;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_e;

  // input unpack
  logic [ID_W-1:0]    in_nid, in_oid;
  logic [WGT_W-1:0]   in_wval;
  logic [COORD_W-1:0] in_x, in_y;
  logic [REACH_W-1:0] in_reach;
  assign in_nid   = s_axis_tdata_i[5:0];
  assign in_oid   = s_axis_tdata_i[11:6];
  assign in_wval  = s_axis_tdata_i[43:12];
  assign in_x     = s_axis_tdata_i[75:44];
  assign in_y     = s_axis_tdata_i[107:76];
  assign in_reach = s_axis_tdata_i[138:108];

  state_e              state_q;
  logic                is_wrk_q;
  logic [ID_W-1:0]     nid_q;
  logic [COORD_W-1:0]  px_q, py_q;
  logic [REACH_W-1:0]  rch_q;
  logic [CNT_W-1:0]    wcnt_q, tcnt_q, lim_q, rd_q;
  logic [IDX_W-1:0]    me_q, best_q, idx1_q, idx2_q, idx3_q;
  logic                v1_q, v2_q, v3_q, found_q;
  logic [WGT_W-1:0]    bw_q, w3_q;
  logic                elig3_q, used2_q, inr2_q;
  logic [SQ_W-1:0]     dx2_q, dy2_q;
  logic [R2_W-1:0]     r2_q;
  logic [UTIL_W-1:0]   util_q;
  logic [1:0]          rs_status_q;
  logic [IDXO_W-1:0]   rs_new_q;
  logic                mv_q;
  logic [1:0]          mstat_q;
  logic [IDXO_W-1:0]   mpart_q, mnew_q;
  logic [WGT_W-1:0]    mw_q;
  logic [UTIL_W-1:0]   mtot_q;

  // memories
  worker_ent_t wrk_mem [MAX_WORKERS];
  task_ent_t   tsk_mem [MAX_TASKS];
  logic        wused_mem [MAX_WORKERS];
  logic        tused_mem [MAX_TASKS];
  logic [WGT_W-1:0] wgt_mem [WDEPTH];
  worker_ent_t wrk_rd_q;
  task_ent_t   tsk_rd_q;
  logic        wused_rd_q, tused_rd_q;
  logic [WGT_W-1:0] wgt_rd_q;

  logic acc, is_load_in, scan_end, fin, wrk_app, tsk_app, out_ld;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign acc      = s_axis_tvalid_i & s_axis_tready_o;
  assign wrk_app  = acc && s_axis_tuser_i == REQ_WORKER && wcnt_q < CNT_W'(MAX_WORKERS);
  assign tsk_app  = acc && s_axis_tuser_i == REQ_TASK && tcnt_q < CNT_W'(MAX_TASKS);
  assign is_load_in = acc && s_axis_tuser_i == REQ_LOAD;
  assign scan_end = (state_q == S_SCAN) && (rd_q >= lim_q) && !v1_q && !v2_q && !v3_q;
  assign fin      = scan_end;
  assign out_ld   = (state_q == S_DONE) && (!mv_q || m_axis_tready_i);

  // weight load
  logic ld_inr;
  logic [WMA_W-1:0] ld_addr;
  assign ld_inr  = (32'(in_nid) < MAX_IDS) && (32'(in_oid) < MAX_IDS);
  assign ld_addr = WMA_W'(WMA_W'(in_nid) * WMA_W'(MAX_IDS) + WMA_W'(in_oid));

  // stage 1: distance and weight address
  logic [COORD_W-1:0] sx, sy;
  logic [REACH_W-1:0] sr;
  logic [ID_W-1:0]    wid, tid;
  logic               s_used, s_inr;
  logic signed [COORD_W:0] dxs, dys;
  logic [COORD_W:0]   dxa, dya;
  logic [WMA_W-1:0]   rd_waddr;

  always_comb begin
    if (is_wrk_q) begin
      sx = tsk_rd_q.x; sy = tsk_rd_q.y; sr = rch_q;
      wid = nid_q; tid = tsk_rd_q.id; s_used = tused_rd_q;
    end else begin
      sx = wrk_rd_q.x; sy = wrk_rd_q.y; sr = wrk_rd_q.reach;
      wid = wrk_rd_q.id; tid = nid_q; s_used = wused_rd_q;
    end
    dxs = $signed({px_q[COORD_W-1], px_q}) - $signed({sx[COORD_W-1], sx});
    dys = $signed({py_q[COORD_W-1], py_q}) - $signed({sy[COORD_W-1], sy});
    dxa = dxs[COORD_W] ? (COORD_W+1)'(-dxs) : dxs;
    dya = dys[COORD_W] ? (COORD_W+1)'(-dys) : dys;
    s_inr = (32'(wid) < MAX_IDS) && (32'(tid) < MAX_IDS);
    rd_waddr = WMA_W'(WMA_W'(wid) * WMA_W'(MAX_IDS) + WMA_W'(tid));
  end

  // stage 2: reach test
  logic [SQ_W:0] dsum;
  logic          elig2;
  assign dsum  = {1'b0, dx2_q} + {1'b0, dy2_q};
  assign elig2 = !used2_q && (dsum <= (SQ_W+1)'(r2_q));

  // used bit write ports
  logic            wu_we, wu_d, tu_we, tu_d;
  logic [WA_W-1:0] wu_a;
  logic [TA_W-1:0] tu_a;
  always_comb begin
    wu_we = 1'b0; wu_d = 1'b0; wu_a = WA_W'(wcnt_q);
    tu_we = 1'b0; tu_d = 1'b0; tu_a = TA_W'(tcnt_q);
    if (wrk_app) wu_we = 1'b1;
    if (tsk_app) tu_we = 1'b1;
    if (fin && found_q) begin
      wu_we = 1'b1; wu_d = 1'b1; tu_we = 1'b1; tu_d = 1'b1;
      wu_a = is_wrk_q ? WA_W'(me_q) : WA_W'(best_q);
      tu_a = is_wrk_q ? TA_W'(best_q) : TA_W'(me_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wrk_app) wrk_mem[WA_W'(wcnt_q)] <= '{reach: in_reach, y: in_y, x: in_x, id: in_nid};
    wrk_rd_q <= wrk_mem[WA_W'(rd_q)];
  end

  always_ff @(posedge clk_i) begin
    if (tsk_app) tsk_mem[TA_W'(tcnt_q)] <= '{y: in_y, x: in_x, id: in_nid};
    tsk_rd_q <= tsk_mem[TA_W'(rd_q)];
  end

  always_ff @(posedge clk_i) begin
    if (wu_we) wused_mem[wu_a] <= wu_d;
    wused_rd_q <= wused_mem[WA_W'(rd_q)];
  end

  always_ff @(posedge clk_i) begin
    if (tu_we) tused_mem[tu_a] <= tu_d;
    tused_rd_q <= tused_mem[TA_W'(rd_q)];
  end

  always_ff @(posedge clk_i) begin
    if (is_load_in && ld_inr) wgt_mem[ld_addr] <= in_wval;
    wgt_rd_q <= wgt_mem[rd_waddr];
  end

  // datapath stages
  always_ff @(posedge clk_i) begin
    idx1_q  <= IDX_W'(rd_q);
    dx2_q   <= SQ_W'(dxa * dxa);
    dy2_q   <= SQ_W'(dya * dya);
    r2_q    <= R2_W'(sr * sr);
    used2_q <= s_used;
    inr2_q  <= s_inr;
    idx2_q  <= idx1_q;
    elig3_q <= elig2;
    w3_q    <= inr2_q ? wgt_rd_q : '0;
    idx3_q  <= idx2_q;
  end

  logic [UTIL_W:0] usum;
  assign usum = {1'b0, util_q} + (UTIL_W+1)'(bw_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      is_wrk_q    <= 1'b0;
      nid_q       <= '0;
      px_q        <= '0;
      py_q        <= '0;
      rch_q       <= '0;
      wcnt_q      <= '0;
      tcnt_q      <= '0;
      lim_q       <= '0;
      rd_q        <= '0;
      me_q        <= '0;
      best_q      <= '0;
      bw_q        <= '0;
      found_q     <= 1'b0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      util_q      <= '0;
      rs_status_q <= ST_NONE;
      rs_new_q    <= '0;
      mv_q        <= 1'b0;
      mstat_q     <= ST_NONE;
      mpart_q     <= '0;
      mnew_q      <= '0;
      mw_q        <= '0;
      mtot_q      <= '0;
    end else begin
      if (out_ld) mv_q <= 1'b1;
      else if (m_axis_tready_i) mv_q <= 1'b0;
      v1_q <= (state_q == S_SCAN) && (rd_q < lim_q);
      v2_q <= v1_q;
      v3_q <= v2_q;
      case (state_q)
        S_IDLE: begin
          if (acc) begin
            is_wrk_q <= (s_axis_tuser_i == REQ_WORKER);
            nid_q    <= in_nid;
            px_q     <= in_x;
            py_q     <= in_y;
            rch_q    <= in_reach;
            rd_q     <= '0;
            found_q  <= 1'b0;
            bw_q     <= '0;
            best_q   <= '0;
            case (s_axis_tuser_i)
              REQ_LOAD: begin
                rs_status_q <= ST_LOADED;
                rs_new_q    <= '0;
                state_q     <= S_DONE;
              end
              REQ_WORKER: begin
                if (wrk_app) begin
                  rs_status_q <= ST_NONE;
                  me_q     <= IDX_W'(wcnt_q);
                  rs_new_q <= IDXO_W'(wcnt_q);
                  wcnt_q   <= wcnt_q + 1'b1;
                  lim_q    <= tcnt_q;
                  state_q  <= S_SCAN;
                end else begin
                  rs_status_q <= ST_FULL;
                  rs_new_q    <= '0;
                  state_q     <= S_DONE;
                end
              end
              REQ_TASK: begin
                if (tsk_app) begin
                  rs_status_q <= ST_NONE;
                  me_q     <= IDX_W'(tcnt_q);
                  rs_new_q <= IDXO_W'(tcnt_q);
                  tcnt_q   <= tcnt_q + 1'b1;
                  lim_q    <= wcnt_q;
                  state_q  <= S_SCAN;
                end else begin
                  rs_status_q <= ST_FULL;
                  rs_new_q    <= '0;
                  state_q     <= S_DONE;
                end
              end
              default: begin
                rs_status_q <= ST_NONE;
                rs_new_q    <= '0;
                state_q     <= S_DONE;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (rd_q < lim_q) begin
            rd_q <= rd_q + 1'b1;
          end
          if (v3_q && elig3_q && (!found_q || w3_q > bw_q)) begin
            found_q <= 1'b1;
            bw_q    <= w3_q;
            best_q  <= idx3_q;
          end
          if (fin) begin
            if (found_q) begin
              rs_status_q <= ST_MATCHED;
              util_q <= usum[UTIL_W] ? '1 : usum[UTIL_W-1:0];
            end
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_ld) begin
            mstat_q <= rs_status_q;
            mpart_q <= found_q ? IDXO_W'(best_q) : '0;
            mnew_q  <= rs_new_q;
            mw_q    <= found_q ? bw_q : '0;
            mtot_q  <= util_q;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o = mv_q;
  assign m_axis_tuser_o  = mstat_q;
  assign m_axis_tdata_o  = {4'b0, mtot_q, mw_q, mnew_q, mpart_q};

endmodule

FILE: tb/sv/tb_online_best_partner_matcher.sv
// ----------------------------------------------------------------------------
// tb_online_best_partner_matcher
// Stream testbench for the matcher: loads weights, then drives workers, tasks,
// further loads and unknown requests, and checks every result item against a behavioral matcher model.
// ----------------------------------------------------------------------------
module tb_online_best_partner_matcher;
  timeunit 1ns;
  timeprecision 1ps;
  import obpm_pkg::*;

  typedef struct packed {
    logic [1:0]  req;
    logic [5:0]  nid;
    logic [5:0]  oid;
    logic [31:0] wval;
    logic [31:0] px;
    logic [31:0] py;
    logic [30:0] rch;
  } req_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  partner;
    logic [5:0]  newidx;
    logic [31:0] mw;
    logic [47:0] util;
  } match_res_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [143:0] s_axis_tdata_i = '0;
  logic [1:0]   s_axis_tuser_i = '0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [95:0]  m_axis_tdata_o;
  logic [1:0]   m_axis_tuser_o;

  online_best_partner_matcher uut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // model state
  logic [31:0] wmem [4096];
  bit          wset [4096];
  logic [5:0]  wk_id [64];
  logic signed [31:0] wk_x [64], wk_y [64];
  logic [30:0] wk_r [64];
  bit          wk_used [64];
  logic [5:0]  tk_id [64];
  logic signed [31:0] tk_x [64], tk_y [64];
  bit          tk_used [64];
  int          n_wk, n_tk;
  logic [47:0] util_sum;

  match_res_t expected_q [$];
  int errors, n_sent, n_got, n_match, n_full;

  function automatic bit within_reach(logic signed [31:0] ax, logic signed [31:0] ay,
                                      logic [30:0] r, logic signed [31:0] bx,
                                      logic signed [31:0] by);
    logic signed [33:0] dx, dy;
    logic [65:0] d2;
    logic [62:0] r2;
    dx = ax - bx;
    dy = ay - by;
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    d2 = 66'(dx) * 66'(dx) + 66'(dy) * 66'(dy);
    r2 = 63'(r) * 63'(r);
    return d2 <= 66'(r2);
  endfunction

  function automatic match_res_t predict_match(req_item_t it);
    match_res_t r;
    bit found;
    int best;
    logic [31:0] bw, w;
    logic [48:0] s;
    r = '0;
    found = 0;
    best = 0;
    bw = 0;
    if (it.req == REQ_LOAD) begin
      wmem[{it.nid, it.oid}] = it.wval;
      wset[{it.nid, it.oid}] = 1;
      r.status = ST_LOADED;
    end else if (it.req == REQ_WORKER) begin
      if (n_wk >= 64) r.status = ST_FULL;
      else begin
        wk_id[n_wk] = it.nid; wk_x[n_wk] = it.px; wk_y[n_wk] = it.py;
        wk_r[n_wk] = it.rch; wk_used[n_wk] = 0;
        r.newidx = n_wk[5:0];
        for (int i = 0; i < n_tk; i++) begin
          if (tk_used[i] || !within_reach(it.px, it.py, it.rch, tk_x[i], tk_y[i]))
            continue;
          w = wmem[{it.nid, tk_id[i]}];
          if (!found || w > bw) begin
            found = 1; bw = w; best = i;
          end
        end
        if (found) begin
          tk_used[best] = 1; wk_used[n_wk] = 1;
        end
        n_wk++;
      end
    end else if (it.req == REQ_TASK) begin
      if (n_tk >= 64) r.status = ST_FULL;
      else begin
        tk_id[n_tk] = it.nid; tk_x[n_tk] = it.px; tk_y[n_tk] = it.py;
        tk_used[n_tk] = 0;
        r.newidx = n_tk[5:0];
        for (int i = 0; i < n_wk; i++) begin
          if (wk_used[i] || !within_reach(wk_x[i], wk_y[i], wk_r[i], it.px, it.py))
            continue;
          w = wmem[{wk_id[i], it.nid}];
          if (!found || w > bw) begin
            found = 1; bw = w; best = i;
          end
        end
        if (found) begin
          wk_used[best] = 1; tk_used[n_tk] = 1;
        end
        n_tk++;
      end
    end
    if (found) begin
      r.status = ST_MATCHED;
      r.partner = best[5:0];
      r.mw = bw;
      s = {1'b0, util_sum} + 49'(bw);
      util_sum = s[48] ? '1 : s[47:0];
    end
    r.util = util_sum;
    return r;
  endfunction

  // all weights get written first so no arrival reads an unwritten word
  task automatic send_item(req_item_t it, bit has_ref = 0, match_res_t ref_r = '0);
    match_res_t p;
    int gap;
    gap = $urandom_range(0, 5);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    p = predict_match(it);
    if (has_ref && p != ref_r) begin
      $error("table row disagrees with model: exp %h got %h", ref_r, p);
      errors++;
    end
    expected_q.insert(expected_q.size(), p);
    s_axis_tdata_i <= {5'd0, it.rch, it.py, it.px, it.wval, it.oid, it.nid};
    s_axis_tuser_i <= it.req;
    s_axis_tvalid_i <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    n_sent++;
  endtask

  // result side
  initial begin
    int stall;
    forever begin
      stall = $urandom_range(0, 5);
      if ($urandom_range(0, 3) == 0) stall = 0;
      if (stall > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      n_got++;
      if (expected_q.size() == 0) begin
        $error("unexpected result item %h status %h", m_axis_tdata_o, m_axis_tuser_o);
        errors++;
      end else begin
        match_res_t e;
        e = expected_q.pop_front();
        if (m_axis_tuser_o !== e.status) begin
          $error("status exp %0d got %0d", e.status, m_axis_tuser_o); errors++;
        end
        if (m_axis_tdata_o[5:0] !== e.partner) begin
          $error("partner_index exp %0d got %0d", e.partner, m_axis_tdata_o[5:0]);
          errors++;
        end
        if (m_axis_tdata_o[11:6] !== e.newidx) begin
          $error("new_index exp %0d got %0d", e.newidx, m_axis_tdata_o[11:6]); errors++;
        end
        if (m_axis_tdata_o[43:12] !== e.mw) begin
          $error("match_weight exp %h got %h", e.mw, m_axis_tdata_o[43:12]); errors++;
        end
        if (m_axis_tdata_o[91:44] !== e.util) begin
          $error("total_utility exp %h got %h", e.util, m_axis_tdata_o[91:44]); errors++;
        end
        if (e.status == ST_MATCHED) n_match++;
        if (e.status == ST_FULL) n_full++;
      end
    end
  end

  function automatic logic [31:0] near_coord();
    return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
  endfunction

  // ids come from a small set whose weights all get loaded
  function automatic logic [5:0] pick_id();
    return ($urandom_range(0, 8) == 8) ? 6'd63 : 6'($urandom_range(0, 7));
  endfunction

  function automatic req_item_t rand_arrival(logic [1:0] kind);
    req_item_t it;
    it.req = kind;
    it.nid = pick_id();
    it.oid = pick_id();
    it.wval = $urandom;
    if ($urandom_range(0, 9) == 0) begin
      it.px = $urandom; it.py = $urandom; it.rch = 31'($urandom);
    end else begin
      it.px = near_coord(); it.py = near_coord();
      it.rch = 31'($urandom_range(0, 6 << 16));
    end
    return it;
  endfunction

  task automatic drain();
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic reset_model();
    n_wk = 0; n_tk = 0; util_sum = '0;
  endtask

  typedef struct {
    req_item_t   it;
    bit          has_ref;
    match_res_t  r;
  } dir_row_t;

  initial begin
    dir_row_t rows [$];
    req_item_t it;
    errors = 0; n_sent = 0; n_got = 0; n_match = 0; n_full = 0;
    reset_model();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // weight table over ids 0..7 and 63: extremes on a few pairs, random elsewhere
    for (int a = 0; a < 9; a++)
      for (int b = 0; b < 9; b++) begin
        it = '0; it.req = REQ_LOAD;
        it.nid = (a == 8) ? 6'd63 : 6'(a);
        it.oid = (b == 8) ? 6'd63 : 6'(b);
        it.wval = (a == 0 && b == 0) ? 32'hFFFF_FFFF :
                  (a == 1 && b == 1) ? 32'h0 : $urandom;
        if (a == 8 && b == 8) it.wval = 32'hFFFF_FFFF;
        if (a == 2 && b == 3) it.wval = 32'h5;
        if (a == 4 && b == 3) it.wval = 32'h5;
        it.px = $urandom; it.py = $urandom; it.rch = 31'($urandom);
        send_item(it, 1, '{status: ST_LOADED, partner: 0, newidx: 0, mw: 0, util: 0});
      end

    // directed table
    // task with empty worker store: no match, index 0
    rows.insert(rows.size(),
                '{'{REQ_TASK, 6'd0, 6'd0, 32'd0, 32'h8000_0000, 32'h7FFF_FFFF, 31'd0},
                  1, '{ST_NONE, 6'd0, 6'd0, 32'd0, 48'd0}});
    // worker at extreme corner, max reach: cannot reach the opposite corner exactly
    rows.insert(rows.size(), '{'{REQ_WORKER, 6'd0, 6'd63, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                                 32'h8000_0000, 31'h7FFF_FFFF}, 0, '0});
    // zero reach, same point: matches at distance zero, weight zero
    rows.insert(rows.size(),
                '{'{REQ_TASK, 6'd1, 6'd0, 32'd0, 32'h100, 32'h100, 31'd0}, 0, '0});
    rows.insert(rows.size(),
                '{'{REQ_WORKER, 6'd1, 6'd0, 32'd0, 32'h100, 32'h100, 31'd0}, 0, '0});
    // tie: two workers with equal weight 5, lowest index wins
    rows.insert(rows.size(),
                '{'{REQ_WORKER, 6'd2, 6'd0, 32'd0, 32'h0, 32'h0, 31'h10000}, 0, '0});
    rows.insert(rows.size(),
                '{'{REQ_WORKER, 6'd4, 6'd0, 32'd0, 32'h0, 32'h0, 31'h10000}, 0, '0});
    rows.insert(rows.size(),
                '{'{REQ_TASK, 6'd3, 6'd0, 32'd0, 32'h0, 32'h0, 31'd0}, 0, '0});
    // radius is the worker's: task reach field ignored
    rows.insert(rows.size(),
                '{'{REQ_TASK, 6'd3, 6'd0, 32'd0, 32'h0, 32'h0, 31'h7FFF_FFFF}, 0, '0});
    // max weight pair
    rows.insert(rows.size(),
                '{'{REQ_TASK, 6'd63, 6'd0, 32'd0, 32'h0, 32'h0, 31'd0}, 0, '0});
    rows.insert(rows.size(),
                '{'{REQ_WORKER, 6'd63, 6'd0, 32'd0, 32'h0, 32'h0, 31'h7FFF_FFFF}, 0, '0});
    // unknown request
    rows.insert(rows.size(), '{'{2'd3, 6'h3F, 6'h3F, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                 32'hFFFF_FFFF, 31'h7FFF_FFFF}, 0, '0});
    foreach (rows[i]) send_item(rows[i].it, rows[i].has_ref, rows[i].r);

    // random: mostly arrivals near the origin, a few loads and unknowns;
    // stores fill up so the full case is hit, and weights are reloaded throughout
    for (int k = 0; k < 600; k++) begin
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 45) it = rand_arrival(REQ_WORKER);
      else if (sel < 90) it = rand_arrival(REQ_TASK);
      else if (sel < 97) begin
        it = rand_arrival(REQ_LOAD);
        if ($urandom_range(0, 3) == 0) it.wval = $urandom_range(0, 1) ? '1 : '0;
      end else it = rand_arrival(2'd3);
      send_item(it);
    end
    s_axis_tvalid_i <= 1'b0;

    drain();
    $display("sent %0d items, %0d results, %0d matches, %0d dropped on full store",
             n_sent, n_got, n_match, n_full);
    $display("final utility %h", util_sum);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end

endmodule
